[sv/stereo_hermite_resampler_core_macros.svh]
// Assertion macros for the resampler checker.
// The expanding scope must provide clk and rst_n.
`ifndef STEREO_HERMITE_RESAMPLER_CORE_MACROS_SVH
`define STEREO_HERMITE_RESAMPLER_CORE_MACROS_SVH

// Antecedent in one cycle implies consequent in the next; quiet during reset.
`define SHRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shrc: next-cycle check failed");

// Reset seen at one edge implies the consequent at the next edge.
`define SHRC_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("shrc: post-reset check failed");

`endif

[sv/shrc_pkg.sv]
package shrc_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 18;
  localparam int DIFF_W   = SAMPLE_W + 1;

  localparam logic [STEP_W-1:0]          STEP_RESET = 18'd65536;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Cap on output frames per input frame
  localparam int OUT_CAP = 16;
  localparam int CNT_W   = 5;

  // Transaction payloads
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } shrc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last;
  } shrc_out_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
  } shrc_cfg_t;

  // Multiplier operand selection
  localparam logic [2:0] MS_UU  = 3'd0;  // u * u
  localparam logic [2:0] MS_M2U = 3'd1;  // mu2 * u
  localparam logic [2:0] MS_A0B = 3'd2;  // A0 * b
  localparam logic [2:0] MS_A3C = 3'd3;  // A3 * c
  localparam logic [2:0] MS_A1D = 3'd4;  // A1 * (c - a)
  localparam logic [2:0] MS_A2D = 3'd5;  // A2 * (d - b)

  // Use of the registered product
  localparam logic [2:0] PR_NONE = 3'd0;
  localparam logic [2:0] PR_MU2  = 3'd1;
  localparam logic [2:0] PR_MU3  = 3'd2;
  localparam logic [2:0] PR_SET2 = 3'd3;  // acc = 2 * prod
  localparam logic [2:0] PR_ADD2 = 3'd4;  // acc += 2 * prod
  localparam logic [2:0] PR_ADD1 = 3'd5;  // acc += prod

  // Sequencing
  localparam logic [1:0] SQ_NEXT   = 2'd0;
  localparam logic [1:0] SQ_ACCEPT = 2'd1;
  localparam logic [1:0] SQ_EMIT   = 2'd2;
  localparam logic [1:0] SQ_FINISH = 2'd3;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  // Microprogram addresses
  localparam int UA_W = 5;
  localparam logic [UA_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [UA_W-1:0] ST_START = 5'd1;
  localparam logic [UA_W-1:0] ST_EMIT  = 5'd15;
  localparam logic [UA_W-1:0] ST_FIN   = 5'd16;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic       ch;
    logic [2:0] pr_op;
    logic       coef_ld;
    logic       res_ld;
    logic [1:0] seq;
  } shrc_uc_t;

  typedef struct packed {
    shrc_uc_t uc;
    logic     accept;
    logic     emit;
    logic     finish;
  } shrc_ctrl_t;

  typedef struct packed {
    logic phase_le_one;
    logic last;
  } shrc_stat_t;

  // Control store
  function automatic shrc_uc_t uc_rom(input logic [UA_W-1:0] addr);
    shrc_uc_t w;
    w = '{mul_sel: MS_UU, ch: CH_LEFT, pr_op: PR_NONE, coef_ld: 1'b0,
          res_ld: 1'b0, seq: SQ_NEXT};
    unique case (addr)
      5'd0:  w.seq = SQ_ACCEPT;
      5'd1:  w.mul_sel = MS_UU;
      5'd2:  w.pr_op = PR_MU2;
      5'd3:  w.mul_sel = MS_M2U;
      5'd4:  w.pr_op = PR_MU3;
      5'd5:  w.coef_ld = 1'b1;
      5'd6:  w.mul_sel = MS_A0B;
      5'd7:  begin
        w.pr_op = PR_SET2; w.mul_sel = MS_A3C;
      end
      5'd8:  begin
        w.pr_op = PR_ADD2; w.mul_sel = MS_A1D;
      end
      5'd9:  begin
        w.pr_op = PR_ADD1; w.mul_sel = MS_A2D;
      end
      5'd10: begin
        w.pr_op = PR_ADD1; w.mul_sel = MS_A0B; w.ch = CH_RIGHT;
      end
      5'd11: begin
        w.pr_op = PR_SET2; w.res_ld = 1'b1; w.mul_sel = MS_A3C; w.ch = CH_RIGHT;
      end
      5'd12: begin
        w.pr_op = PR_ADD2; w.mul_sel = MS_A1D; w.ch = CH_RIGHT;
      end
      5'd13: begin
        w.pr_op = PR_ADD1; w.mul_sel = MS_A2D; w.ch = CH_RIGHT;
      end
      5'd14: w.pr_op = PR_ADD1;
      5'd15: w.seq = SQ_EMIT;
      5'd16: w.seq = SQ_FINISH;
      default: w.seq = SQ_FINISH;
    endcase
    return w;
  endfunction

endpackage

[sv/shrc_stream_if.sv]
interface shrc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/shrc_seq.sv]
module shrc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  shrc_pkg::shrc_stat_t stat,
  output shrc_pkg::shrc_ctrl_t ctrl
);

  logic [shrc_pkg::UA_W-1:0] step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  shrc_pkg::shrc_uc_t        uc;
  logic                      accept;
  logic                      out_load;

  // Decode current control word and handshakes
  always_comb begin
    uc       = shrc_pkg::uc_rom(step_r);
    in_ready = (uc.seq == shrc_pkg::SQ_ACCEPT);
    accept   = in_ready && in_valid;
    out_load = (uc.seq == shrc_pkg::SQ_EMIT) && (!out_valid_r || out_ready);
  end

  // Step counter with conditional jumps
  always_comb begin
    step_nxt = step_r;
    unique case (uc.seq)
      shrc_pkg::SQ_NEXT:   step_nxt = step_r + 1'b1;
      shrc_pkg::SQ_ACCEPT: begin
        if (accept) begin
          step_nxt = stat.phase_le_one ? shrc_pkg::ST_START : shrc_pkg::ST_FIN;
        end
      end
      shrc_pkg::SQ_EMIT: begin
        if (out_load) begin
          step_nxt = stat.last ? shrc_pkg::ST_FIN : shrc_pkg::ST_START;
        end
      end
      shrc_pkg::SQ_FINISH: step_nxt = shrc_pkg::ST_IDLE;
      default:             step_nxt = shrc_pkg::ST_IDLE;
    endcase
  end

  // Output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= shrc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign ctrl.uc     = uc;
  assign ctrl.accept = accept;
  assign ctrl.emit   = out_load;
  assign ctrl.finish = (uc.seq == shrc_pkg::SQ_FINISH);

endmodule

[sv/shrc_dp.sv]
module shrc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [shrc_pkg::STEP_W-1:0]   cfg_step,
  input  shrc_pkg::shrc_in_t            in_data,
  input  shrc_pkg::shrc_ctrl_t          ctrl,
  output shrc_pkg::shrc_stat_t          stat,
  output shrc_pkg::shrc_out_t           out_data
);

  localparam int PHW  = ((FRAC_BITS > shrc_pkg::STEP_W) ? FRAC_BITS : shrc_pkg::STEP_W) + 2;
  localparam int UW   = FRAC_BITS + 1;
  localparam int CW   = FRAC_BITS + 3;
  localparam int MA_W = CW;
  localparam int MB_W = (FRAC_BITS + 2 > shrc_pkg::DIFF_W) ? FRAC_BITS + 2 : shrc_pkg::DIFF_W;
  localparam int PW   = MA_W + MB_W;
  localparam int AW   = PW + 3;
  localparam int SW   = shrc_pkg::SAMPLE_W;
  localparam int DW   = shrc_pkg::DIFF_W;
  localparam logic [PHW-1:0] ONE = PHW'(1) << FRAC_BITS;
  localparam logic signed [AW-1:0] RES_MAX = AW'(shrc_pkg::SAMPLE_MAX);
  localparam logic signed [AW-1:0] RES_MIN = AW'(shrc_pkg::SAMPLE_MIN);

  // Configuration and sequencing state
  logic [shrc_pkg::STEP_W-1:0] step_r;
  logic [PHW-1:0]              phase_r;
  logic [shrc_pkg::CNT_W-1:0]  cnt_r;

  // History (entry 0 oldest) and its registered differences
  logic signed [SW-1:0] hl_r [4];
  logic signed [SW-1:0] hr_r [4];
  logic signed [DW-1:0] dca_l_r, ddb_l_r, dca_r_r, ddb_r_r;
  logic signed [SW-1:0] in_l_r, in_r_r;

  // Interpolation datapath
  logic [UW-1:0]        mu2_r, mu3_r;
  logic signed [CW-1:0] a0_r, a1_r, a2_r, a3_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] left_res_r;
  shrc_pkg::shrc_out_t  out_r;

  logic [UW-1:0]          u;
  logic signed [SW-1:0]   b_sel, c_sel;
  logic signed [DW-1:0]   dca_sel, ddb_sel;
  logic signed [MA_W-1:0] opa;
  logic signed [MB_W-1:0] opb;
  logic signed [CW-1:0]   m2s, m3s, us, s_c;
  logic signed [AW-1:0]   prod_ext, q;
  logic signed [SW-1:0]   res_now;
  logic [PHW-1:0]         phase_sum;
  logic                   last_c;

  assign u = phase_r[UW-1:0];

  // Channel operand select
  always_comb begin
    if (ctrl.uc.ch == shrc_pkg::CH_RIGHT) begin
      b_sel = hr_r[1]; c_sel = hr_r[2]; dca_sel = dca_r_r; ddb_sel = ddb_r_r;
    end else begin
      b_sel = hl_r[1]; c_sel = hl_r[2]; dca_sel = dca_l_r; ddb_sel = ddb_l_r;
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (ctrl.uc.mul_sel)
      shrc_pkg::MS_UU: begin
        opa = MA_W'(u); opb = MB_W'(u);
      end
      shrc_pkg::MS_M2U: begin
        opa = MA_W'(mu2_r); opb = MB_W'(u);
      end
      shrc_pkg::MS_A0B: begin
        opa = a0_r; opb = MB_W'(b_sel);
      end
      shrc_pkg::MS_A3C: begin
        opa = a3_r; opb = MB_W'(c_sel);
      end
      shrc_pkg::MS_A1D: begin
        opa = a1_r; opb = MB_W'(dca_sel);
      end
      shrc_pkg::MS_A2D: begin
        opa = a2_r; opb = MB_W'(ddb_sel);
      end
      default: begin
        opa = '0; opb = '0;
      end
    endcase
  end

  // Signed mu, mu^2, mu^3 and scale S for the Hermite basis weights
  always_comb begin
    m2s = CW'(mu2_r);
    m3s = CW'(mu3_r);
    us  = CW'(u);
    s_c = CW'(1) << FRAC_BITS;
  end

  // Accumulator update
  assign prod_ext = AW'(prod_r);
  always_comb begin
    case (ctrl.uc.pr_op)
      shrc_pkg::PR_SET2: acc_nxt = prod_ext <<< 1;
      shrc_pkg::PR_ADD2: acc_nxt = acc_r + (prod_ext <<< 1);
      shrc_pkg::PR_ADD1: acc_nxt = acc_r + prod_ext;
      default:           acc_nxt = acc_r;
    endcase
  end

  // Divide by 2S toward zero, then clamp
  always_comb begin
    q = acc_r >>> (FRAC_BITS + 1);
    if (acc_r[AW-1] && (|acc_r[FRAC_BITS:0])) begin
      q = q + AW'(1);
    end
    if (q > RES_MAX) begin
      res_now = shrc_pkg::SAMPLE_MAX;
    end else if (q < RES_MIN) begin
      res_now = shrc_pkg::SAMPLE_MIN;
    end else begin
      res_now = q[SW-1:0];
    end
  end

  // Next phase and end-of-burst flag
  always_comb begin
    phase_sum = phase_r + PHW'(step_r);
    last_c    = (phase_sum > ONE) ||
                (cnt_r == shrc_pkg::CNT_W'(shrc_pkg::OUT_CAP - 1));
  end

  assign stat.phase_le_one = (phase_r <= ONE);
  assign stat.last         = last_c;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= shrc_pkg::STEP_RESET;
      phase_r <= ONE;
      cnt_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        hl_r[i] <= '0;
        hr_r[i] <= '0;
      end
      dca_l_r <= '0;
      ddb_l_r <= '0;
      dca_r_r <= '0;
      ddb_r_r <= '0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_step;
      end
      if (ctrl.accept) begin
        cnt_r <= '0;
      end else if (ctrl.emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctrl.emit) begin
        phase_r <= phase_sum;
      end else if (ctrl.finish) begin
        phase_r <= (phase_r > ONE) ? (phase_r - ONE) : '0;
      end
      // Shift the new frame in once the bursts are done
      if (ctrl.finish) begin
        hl_r[0] <= hl_r[1];
        hl_r[1] <= hl_r[2];
        hl_r[2] <= hl_r[3];
        hl_r[3] <= in_l_r;
        hr_r[0] <= hr_r[1];
        hr_r[1] <= hr_r[2];
        hr_r[2] <= hr_r[3];
        hr_r[3] <= in_r_r;
        dca_l_r <= DW'(hl_r[3]) - DW'(hl_r[1]);
        ddb_l_r <= DW'(in_l_r) - DW'(hl_r[2]);
        dca_r_r <= DW'(hr_r[3]) - DW'(hr_r[1]);
        ddb_r_r <= DW'(in_r_r) - DW'(hr_r[2]);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    acc_r  <= acc_nxt;
    if (ctrl.accept) begin
      in_l_r <= in_data.left_in;
      in_r_r <= in_data.right_in;
    end
    if (ctrl.uc.pr_op == shrc_pkg::PR_MU2) begin
      mu2_r <= prod_r[FRAC_BITS +: UW];
    end
    if (ctrl.uc.pr_op == shrc_pkg::PR_MU3) begin
      mu3_r <= prod_r[FRAC_BITS +: UW];
    end
    if (ctrl.uc.coef_ld) begin
      a0_r <= (m3s <<< 1) - (m2s <<< 1) - m2s + s_c;
      a1_r <= m3s - (m2s <<< 1) + us;
      a2_r <= m3s - m2s;
      a3_r <= (m2s <<< 1) + m2s - (m3s <<< 1);
    end
    if (ctrl.uc.res_ld) begin
      left_res_r <= res_now;
    end
    if (ctrl.emit) begin
      out_r.left_out  <= left_res_r;
      out_r.right_out <= res_now;
      out_r.last      <= last_c;
    end
  end

  assign out_data = out_r;

endmodule

[sv/stereo_hermite_resampler_core.sv]
// Channel   Dir  Payload                         Transaction
// in_if     in   left_in, right_in (s16)         valid & ready
// out_if    out  left_out, right_out (s16), last valid & ready
// cfg_if    in   step (u18, FRAC_BITS frac)      valid & ready (ready tied high)
//
// Per input frame: an accept step, one control-store pass from its start step
// to its emit step per output frame (n = 0..16 outputs), and a finish step;
// the one shared multiplier, stepped by the control store, sets the output slot.
// Reset (rst_n low, synchronous): step = 1.0, phase = 1.0, history zero, idle.
// A held output frame stalls the sequencer only at its emit step; the next
// input can be taken while the last output still waits.
module stereo_hermite_resampler_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  shrc_stream_if.sink   in_if,
  shrc_stream_if.source out_if,
  shrc_stream_if.sink   cfg_if
);

  shrc_pkg::shrc_ctrl_t ctrl;
  shrc_pkg::shrc_stat_t stat;
  shrc_pkg::shrc_cfg_t  cfg_data;

  assign cfg_if.ready = 1'b1;
  assign cfg_data     = cfg_if.data;

  // Microprogram sequencer and handshakes
  shrc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // Interpolation datapath
  shrc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_if.valid),
    .cfg_step (cfg_data.step),
    .in_data  (in_if.data),
    .ctrl     (ctrl),
    .stat     (stat),
    .out_data (out_if.data)
  );

endmodule

[sv/shrc_checker.sv]
`include "stereo_hermite_resampler_core_macros.svh"

module shrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input shrc_pkg::shrc_out_t out_data
);

  // A stalled output frame stays presented unchanged
  `SHRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Each input transaction is followed by in_ready going low
  `SHRC_ASSERT_NEXT(a_in_spacing, in_valid && in_ready, !in_ready)

  // Reset leaves no output pending
  `SHRC_ASSERT_AFTER_RESET(a_reset_empty, !out_valid)

endmodule

bind stereo_hermite_resampler_core shrc_checker u_shrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

[bench/tb.sv]
module tb;

  localparam int FRAC          = 16;
  localparam int PHASE_W       = FRAC + 3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_FRAMES = 200;
  localparam int REPORT_MAX    = 10;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC;

  // Step settings used by the directed tests and the random rounds
  localparam logic [shrc_pkg::STEP_W-1:0] STEP_MIN   = 18'd4096;
  localparam logic [shrc_pkg::STEP_W-1:0] STEP_MAX   = 18'd262143;
  localparam logic [shrc_pkg::STEP_W-1:0] STEP_CAPPED = 18'd2000;
  localparam logic [shrc_pkg::STEP_W-1:0] STEP_ZERO  = 18'd0;
  localparam logic [shrc_pkg::STEP_W-1:0] STEP_HOLD  = 18'd8192;

  // Receiver pacing modes
  localparam logic [1:0] RX_ALWAYS = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_QUARTER = 2'd2;
  localparam logic [1:0] RX_MOSTLY = 2'd3;

  // Tracks the converter state and the output frames still owed
  class frame_ledger;
    logic [shrc_pkg::STEP_W-1:0]          step;
    logic [PHASE_W-1:0]                   phase;
    logic signed [shrc_pkg::SAMPLE_W-1:0] left_hist[4];
    logic signed [shrc_pkg::SAMPLE_W-1:0] right_hist[4];
    shrc_pkg::shrc_out_t                  owed_frames[$];
    int                                   failures;

    function new();
      step = shrc_pkg::STEP_RESET;
      phase = PHASE_ONE;
      for (int i = 0; i < 4; i++) begin
        left_hist[i] = '0;
        right_hist[i] = '0;
      end
      failures = 0;
    endfunction

    function void set_step(logic [shrc_pkg::STEP_W-1:0] v);
      step = v;
    endfunction

    function int pending();
      return owed_frames.size();
    endfunction

    // Four-point Hermite value between b and c at position u
    static function logic signed [shrc_pkg::SAMPLE_W-1:0] hermite(
        logic [PHASE_W-1:0] u,
        logic signed [shrc_pkg::SAMPLE_W-1:0] a,
        logic signed [shrc_pkg::SAMPLE_W-1:0] b,
        logic signed [shrc_pkg::SAMPLE_W-1:0] c,
        logic signed [shrc_pkg::SAMPLE_W-1:0] d);
      longint s, mu, m2, m3, a0, a1, a2, a3, n, r;
      s  = longint'(1) << FRAC;
      mu = longint'(u);
      m2 = (mu * mu) >>> FRAC;
      m3 = (m2 * mu) >>> FRAC;
      a0 = 2 * m3 - 3 * m2 + s;
      a1 = m3 - 2 * m2 + mu;
      a2 = m3 - m2;
      a3 = -2 * m3 + 3 * m2;
      n = 2 * (a0 * longint'(b) + a3 * longint'(c))
          + a1 * (longint'(c) - longint'(a)) + a2 * (longint'(d) - longint'(b));
      r = n / (2 * s);
      if (r > longint'(shrc_pkg::SAMPLE_MAX)) r = longint'(shrc_pkg::SAMPLE_MAX);
      if (r < longint'(shrc_pkg::SAMPLE_MIN)) r = longint'(shrc_pkg::SAMPLE_MIN);
      return r[shrc_pkg::SAMPLE_W-1:0];
    endfunction

    // Accepted input frame: queue the frames it produces, then shift it in
    function void take_frame(shrc_pkg::shrc_in_t f);
      shrc_pkg::shrc_out_t o;
      int                  count;
      logic [PHASE_W:0]    nxt;
      count = 0;
      while (phase <= PHASE_ONE && count < shrc_pkg::OUT_CAP) begin
        o.left_out  = hermite(phase, left_hist[0], left_hist[1], left_hist[2],
                              left_hist[3]);
        o.right_out = hermite(phase, right_hist[0], right_hist[1], right_hist[2],
                              right_hist[3]);
        nxt = {1'b0, phase} + step;
        count++;
        o.last = !(nxt <= PHASE_ONE && count < shrc_pkg::OUT_CAP);
        owed_frames.push_back(o);
        phase = nxt[PHASE_W-1:0];
      end
      // phase past 1.0 carries over; cap reached with phase still in range: restart from zero
      if (phase > PHASE_ONE) phase = phase - PHASE_ONE;
      else phase = '0;
      for (int i = 0; i < 3; i++) begin
        left_hist[i] = left_hist[i+1];
        right_hist[i] = right_hist[i+1];
      end
      left_hist[3] = f.left_in;
      right_hist[3] = f.right_in;
    endfunction

    function void check_frame(shrc_pkg::shrc_out_t got);
      shrc_pkg::shrc_out_t want;
      if (owed_frames.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("unexpected output frame: L=%0d R=%0d last=%0b",
                   got.left_out, got.right_out, got.last);
        return;
      end
      want = owed_frames.pop_front();
      if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
          got.last !== want.last) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display({"output frame mismatch: expected L=%0d R=%0d last=%0b,",
                    " got L=%0d R=%0d last=%0b"},
                   want.left_out, want.right_out, want.last,
                   got.left_out, got.right_out, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic hold_go = 1'b0;
  logic hold_off = 1'b0;
  logic [7:0] rx_tick = '0;
  logic [1:0] rx_mode = RX_ALWAYS;
  logic signed [shrc_pkg::SAMPLE_W-1:0] walk_left = '0;
  logic signed [shrc_pkg::SAMPLE_W-1:0] walk_right = '0;
  frame_ledger book;

  shrc_stream_if #(.data_t(shrc_pkg::shrc_in_t))  in_ch ();
  shrc_stream_if #(.data_t(shrc_pkg::shrc_out_t)) out_ch ();
  shrc_stream_if #(.data_t(shrc_pkg::shrc_cfg_t)) cfg_ch ();

  stereo_hermite_resampler_core #(.FRAC_BITS(FRAC)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("stereo_hermite_resampler_core test failed");
    $finish;
  end

  // Receiver pacing, overridden by the long hold-off
  always @(posedge clk) begin : rx_pace
    logic take;
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick[5:0] == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:  take = 1'b1;
      RX_COIN:    take = 1'($urandom_range(0, 1));
      RX_QUARTER: take = (rx_tick[1:0] == 2'd0);
      default:    take = ($urandom_range(0, 7) != 0);
    endcase
    out_ch.ready <= take && !hold_off;
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_go);
    repeat (5) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Transaction monitor: results first, then the input and step write
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) book.check_frame(out_ch.data);
      if (in_ch.valid && in_ch.ready) book.take_frame(in_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) book.set_step(cfg_ch.data.step);
    end
  end

  task automatic send_frame(int l, int r);
    logic [31:0] lw, rw;
    lw = l;
    rw = r;
    in_ch.valid <= 1'b1;
    in_ch.data  <= shrc_pkg::shrc_in_t'{left_in: lw[shrc_pkg::SAMPLE_W-1:0],
                                        right_in: rw[shrc_pkg::SAMPLE_W-1:0]};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_step(logic [shrc_pkg::STEP_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= shrc_pkg::shrc_cfg_t'{step: v};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every owed frame has arrived and the block has gone quiet
  task automatic settle();
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [shrc_pkg::SAMPLE_W-1:0] next_sample(
      logic signed [shrc_pkg::SAMPLE_W-1:0] prev);
    logic [31:0] w;
    int v;
    w = $urandom;
    case ($urandom_range(0, 5))
      0, 1: return w[shrc_pkg::SAMPLE_W-1:0];
      2: begin
        case ($urandom_range(0, 3))
          0: return shrc_pkg::SAMPLE_MAX;
          1: return shrc_pkg::SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      3, 4: begin
        v = int'(prev) + int'($urandom_range(0, 4000)) - 2000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[shrc_pkg::SAMPLE_W-1:0];
      end
      default: begin
        v = int'($urandom_range(0, 64)) - 32;
        return v[shrc_pkg::SAMPLE_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [shrc_pkg::STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0: return STEP_MIN;
      1: return STEP_MAX;
      2: return shrc_pkg::STEP_RESET;
      3: return shrc_pkg::STEP_W'($urandom_range(4096, 65536));
      4: return shrc_pkg::STEP_W'($urandom_range(65537, 262143));
      default: return shrc_pkg::STEP_W'($urandom_range(4096, 262143));
    endcase
  endfunction

  // Offer n frames in bursts with random gaps between them
  task automatic run_frames(int n);
    int left_to_send, burst, gap;
    left_to_send = n;
    while (left_to_send > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && left_to_send > 0) begin
        walk_left = next_sample(walk_left);
        walk_right = next_sample(walk_right);
        send_frame(walk_left, walk_right);
        burst--;
        left_to_send--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    int sent, n, round;
    book = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset step: each frame lands exactly on history entry 2
    send_frame(0, 0);
    send_frame(32767, -32768);
    send_frame(-32768, 32767);
    send_frame(-1, 1);
    in_ch.valid <= 1'b0;
    settle();

    // Minimum step: sixteen frames per input after the first, alternating extremes overshoot
    write_step(STEP_MIN);
    send_frame(32767, -32768);
    send_frame(-32768, 32767);
    send_frame(32767, -32768);
    send_frame(-32768, 32767);
    send_frame(32767, 32767);
    send_frame(-32768, -32768);
    in_ch.valid <= 1'b0;
    settle();

    // Maximum step: most inputs produce no frame at all
    write_step(STEP_MAX);
    send_frame(32767, -32768);
    send_frame(-32768, 32767);
    send_frame(12345, -12345);
    send_frame(-1, 0);
    in_ch.valid <= 1'b0;
    settle();

    // Step too small: output cap hit, phase restarts at zero
    write_step(STEP_CAPPED);
    send_frame(1000, -1000);
    send_frame(-32768, 32767);
    send_frame(32767, -32768);
    in_ch.valid <= 1'b0;
    settle();

    // Zero step: capped every time, interpolation at position zero
    write_step(STEP_ZERO);
    send_frame(-20000, 20000);
    send_frame(5, -5);
    in_ch.valid <= 1'b0;
    settle();

    // Random rounds, each at its own step
    sent = 0;
    round = 0;
    while (sent < RANDOM_FRAMES) begin
      n = $urandom_range(15, 40);
      if (round == 1) begin
        write_step(STEP_HOLD);
        hold_go <= 1'b1;
        n = 40;
      end else begin
        write_step(pick_step());
      end
      run_frames(n);
      settle();
      sent += n;
      round++;
    end

    if (book.failures == 0 && book.pending() == 0) begin
      $display("stereo_hermite_resampler_core test passed");
    end else begin
      $display("stereo_hermite_resampler_core test failed");
    end
    $finish;
  end

endmodule

[stereo_hermite_resampler_core.f]
+incdir+sv
sv/shrc_pkg.sv
sv/shrc_stream_if.sv
sv/shrc_seq.sv
sv/shrc_dp.sv
sv/stereo_hermite_resampler_core.sv
sv/shrc_checker.sv
bench/tb.sv
